/* rtl/cdtb_pkg.sv */
// ---------------------------------------------------------------------------
// cdtb_pkg
// Shared types, command codes and helpers for the countdown timer bank.
// ---------------------------------------------------------------------------
package cdtb_pkg;

   // default number of timers in the bank
   localparam int TIMER_COUNT_DEF = 8;

   // widths fixed by the command format
   localparam int KIND_W   = 3;
   localparam int INDEX_W  = 4;
   localparam int PERIOD_W = 16;

   // command kinds
   localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_START    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_STOP     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STOP_ALL = 3'd4;
   localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd5;

   // longest period that can be loaded
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'd65534;

   // counter value that marks an expired timer
   localparam logic [PERIOD_W-1:0] COUNT_EXPIRED = 16'd1;

   // one command
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [INDEX_W-1:0]  timer_index;
      logic [PERIOD_W-1:0] period_ms;
   } req_type;

   // one status result
   typedef struct packed {
      logic expired;
      logic running;
      logic index_error;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // capture a new command
      logic walk_step;   // read the next counter of the bank sweep
      logic write_idx;   // start or stop the addressed timer
      logic rd_reload;   // read the addressed reload value
      logic copy;        // copy reload value into the addressed counter
      logic rd_count;    // read the addressed counter for the status
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_walk;     // tick or stop all
      logic is_write;    // start or stop
      logic is_restart;
      logic walk_last;   // sweep is at the last timer
   } dp_status_type;

   // value loaded by start: clamped period plus one
   function automatic logic [PERIOD_W-1:0] start_value(input logic [PERIOD_W-1:0] period);
      logic [PERIOD_W-1:0] clamped;
      clamped = (period > PERIOD_MAX) ? PERIOD_MAX : period;
      return clamped + COUNT_EXPIRED;
   endfunction

endpackage

/* rtl/cdtb_ctrl.sv */
// ---------------------------------------------------------------------------
// cdtb_ctrl
// Sequencer for the timer bank: decodes a command and steps the datapath.
// ---------------------------------------------------------------------------
module cdtb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output cdtb_pkg::ctrl_cmd_type cmd,
   input  cdtb_pkg::dp_status_type status
);
   import cdtb_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_WALK   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_LOAD   = 3'd5;
   localparam logic [2:0] ST_COPY   = 3'd6;
   localparam logic [2:0] ST_READ   = 3'd7;
   localparam logic [2:0] ST_RESP   = 3'd0;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       resp_ff;
   logic       resp_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      resp_in  = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && !resp_ff) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_walk) begin
               state_in = ST_WALK;
            end else if (status.is_write) begin
               state_in = ST_WRITE;
            end else if (status.is_restart) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_READ;
         end
         ST_WRITE: begin
            cmd.write_idx = 1'b1;
            state_in      = ST_READ;
         end
         ST_LOAD: begin
            cmd.rd_reload = 1'b1;
            state_in      = ST_COPY;
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd_count = 1'b1;
            resp_in      = 1'b1;
            state_in     = ST_RESP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and response strobe registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         resp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         resp_ff  <= resp_in;
      end
   end

   // result shows in the cycle after the status read, back in idle
   assign rsp_valid = resp_ff;
   assign busy      = (state_ff != ST_IDLE) || resp_ff;

endmodule

/* rtl/cdtb_datapath.sv */
// ---------------------------------------------------------------------------
// cdtb_datapath
// Counter and reload memories, bank sweep counter and status formatting.
// ---------------------------------------------------------------------------
module cdtb_datapath #(
   parameter int TIMER_COUNT = cdtb_pkg::TIMER_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cdtb_pkg::req_type       req_data,
   input  cdtb_pkg::ctrl_cmd_type  cmd,
   output cdtb_pkg::dp_status_type status,
   output cdtb_pkg::rsp_type       rsp_data
);
   import cdtb_pkg::*;

   localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   // captured command
   req_type             req_ff;
   logic                idx_ok;
   logic [AW-1:0]       idx_addr;

   // bank sweep
   logic [AW-1:0]       walk_ff;
   logic [AW-1:0]       walk_in;
   logic [AW-1:0]       walk_addr_ff;
   logic                walk_pend_ff;
   logic [PERIOD_W-1:0] walk_val;

   // memories and valid bits
   logic [PERIOD_W-1:0]    count_mem [TIMER_COUNT];
   logic [PERIOD_W-1:0]    reload_mem [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] cnt_vld_ff;
   logic [TIMER_COUNT-1:0] rld_vld_ff;
   logic [PERIOD_W-1:0]    count_rd_ff;
   logic [PERIOD_W-1:0]    reload_rd_ff;

   // port controls
   logic                cnt_we;
   logic [AW-1:0]       cnt_waddr;
   logic [PERIOD_W-1:0] cnt_wdata;
   logic                cnt_re;
   logic [AW-1:0]       cnt_raddr;
   logic                rld_we;
   logic                rld_re;

   // command capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   assign idx_ok   = {1'b0, req_ff.timer_index} < (INDEX_W + 1)'(TIMER_COUNT);
   assign idx_addr = AW'(req_ff.timer_index);

   // kind decode for the controller
   always_comb begin
      status.is_walk    = req_ff.kind inside {KIND_TICK, KIND_STOP_ALL};
      status.is_write   = req_ff.kind inside {KIND_START, KIND_STOP};
      status.is_restart = (req_ff.kind == KIND_RESTART);
      status.walk_last  = (walk_ff == AW'(TIMER_COUNT - 1));
   end

   // sweep counter
   always_comb begin
      walk_in = walk_ff;
      if (cmd.load) begin
         walk_in = '0;
      end else if (cmd.walk_step) begin
         walk_in = walk_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff      <= '0;
         walk_pend_ff <= 1'b0;
      end else begin
         walk_ff      <= walk_in;
         walk_pend_ff <= cmd.walk_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_step) begin
         walk_addr_ff <= walk_ff;
      end
   end

   // sweep write-back: stop all clears, tick decrements running counters
   always_comb begin
      if (req_ff.kind == KIND_STOP_ALL) begin
         walk_val = '0;
      end else if (count_rd_ff > COUNT_EXPIRED) begin
         walk_val = count_rd_ff - COUNT_EXPIRED;
      end else begin
         walk_val = count_rd_ff;
      end
   end

   // counter port select
   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = idx_addr;
      cnt_wdata = '0;
      if (walk_pend_ff) begin
         cnt_we    = 1'b1;
         cnt_waddr = walk_addr_ff;
         cnt_wdata = walk_val;
      end else if (cmd.write_idx && idx_ok) begin
         cnt_we    = 1'b1;
         cnt_wdata = (req_ff.kind == KIND_START) ? start_value(req_ff.period_ms) : '0;
      end else if (cmd.copy && idx_ok) begin
         cnt_we    = 1'b1;
         cnt_wdata = reload_rd_ff;
      end
      cnt_re    = cmd.walk_step || (cmd.rd_count && idx_ok);
      cnt_raddr = cmd.walk_step ? walk_ff : idx_addr;
      rld_we    = cmd.write_idx && idx_ok && (req_ff.kind == KIND_START);
      rld_re    = cmd.rd_reload && idx_ok;
   end

   // counter memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         count_rd_ff <= cnt_vld_ff[cnt_raddr] ? count_mem[cnt_raddr] : '0;
      end
   end

   // reload memory
   always_ff @(posedge clock) begin
      if (rld_we) begin
         reload_mem[idx_addr] <= cnt_wdata;
      end
      if (rld_re) begin
         reload_rd_ff <= rld_vld_ff[idx_addr] ? reload_mem[idx_addr] : '0;
      end
   end

   // entries read as zero until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
         rld_vld_ff <= '0;
      end else begin
         if (cnt_we) begin
            cnt_vld_ff[cnt_waddr] <= 1'b1;
         end
         if (rld_we) begin
            rld_vld_ff[idx_addr] <= 1'b1;
         end
      end
   end

   // status of the addressed timer
   always_comb begin
      rsp_data.expired     = idx_ok && (count_rd_ff == COUNT_EXPIRED);
      rsp_data.running     = idx_ok && (count_rd_ff > COUNT_EXPIRED);
      rsp_data.index_error = !idx_ok;
   end

endmodule

/* rtl/countdown_timer_bank.sv */
// ---------------------------------------------------------------------------
// countdown_timer_bank
// Bank of countdown timers driven by one command per transfer.
// ---------------------------------------------------------------------------
// A command transfer takes place when start is high and busy is low; the
// command (tick, start, restart, stop, stop all, query) sits on req_data.
// Every command returns one status transfer on rsp_data, marked by a
// one-cycle rsp_valid strobe; the receiver cannot stall it, so the result
// must be taken in that cycle.
// After a command transfer every kind passes through these states, and
//   query and unused kinds      decode, read
//   start and stop              decode, write, read
//   restart                     decode, reload read, copy, read
//   tick and stop all           decode, sweep step per timer, drain, read
// rsp_valid follows the read. busy stays high until the rsp_valid cycle
// ends, so one command is in flight at a time.
// Tick and stop all sweep the counter memory one timer per cycle, with a
// drain state for the last write-back.
// Reset clears every counter and reload value to zero (all timers stopped)
// through per-entry valid bits, so the block is ready right after reset.
// ---------------------------------------------------------------------------
module countdown_timer_bank #(
   parameter int TIMER_COUNT = cdtb_pkg::TIMER_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cdtb_pkg::req_type req_data,
   output logic              rsp_valid,
   output cdtb_pkg::rsp_type rsp_data
);
   import cdtb_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   cdtb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // storage and status logic
   cdtb_datapath #(
      .TIMER_COUNT (TIMER_COUNT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
